// ===== rtl/core/dwst_pkg.sv =====
// ----------------------------------------------------------------------------
// dwst_pkg
// shared types, constants and helper functions of the daily window slot trigger
// ----------------------------------------------------------------------------
package dwst_pkg;

    // register and minute-of-day width
    localparam int RegW     = 11;
    localparam int CfgIdxW  = 2;
    localparam int DivCntW  = $clog2(RegW);
    localparam int DistW    = RegW + 2;

    localparam logic [DistW-1:0] MinutesPerDay = DistW'(1440);

    // register indexes
    localparam logic [CfgIdxW-1:0] CFG_WINDOW_START = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW_END   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_INTERVAL     = 2'd2;

    // register reset values
    localparam logic [RegW-1:0] WindowStartReset = RegW'(360);
    localparam logic [RegW-1:0] WindowEndReset   = RegW'(1080);
    localparam logic [RegW-1:0] IntervalReset    = RegW'(60);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // hour * 60 + minute, taken as is for out-of-range fields
    function automatic logic [RegW-1:0] minute_of_day(
        input logic [4:0] hour,
        input logic [5:0] minute
    );
        minute_of_day = RegW'({hour, 6'b0}) - RegW'({hour, 2'b0}) + RegW'(minute);
    endfunction

    // (now + 2 days - start) mod 1 day; the sum stays below 4 days
    function automatic logic [RegW-1:0] day_distance(
        input logic [RegW-1:0] now,
        input logic [RegW-1:0] start
    );
        logic [DistW-1:0] sum;
        logic [DistW-1:0] wrapped;
        sum = DistW'(now) + (MinutesPerDay << 1) - DistW'(start);
        if (sum >= (MinutesPerDay * DistW'(3)))
        begin
            wrapped = sum - (MinutesPerDay * DistW'(3));
        end
        else if (sum >= (MinutesPerDay << 1))
        begin
            wrapped = sum - (MinutesPerDay << 1);
        end
        else if (sum >= MinutesPerDay)
        begin
            wrapped = sum - MinutesPerDay;
        end
        else
        begin
            wrapped = sum;
        end
        day_distance = wrapped[RegW-1:0];
    endfunction

endpackage

// ===== rtl/core/dwst_div.sv =====
// ----------------------------------------------------------------------------
// dwst_div
// restoring divider, one quotient bit per cycle through one shared subtractor
// ----------------------------------------------------------------------------
module dwst_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dwst_pkg::RegW-1:0]  dividend,
    input  logic [dwst_pkg::RegW-1:0]  divisor,
    output dwst_pkg::div_status_t      status,
    output logic [dwst_pkg::RegW-1:0]  quotient
);
    import dwst_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [DivCntW-1:0]  count_reg;
    logic [RegW-1:0]     rem_reg;
    logic [RegW-1:0]     quo_reg;
    logic [RegW-1:0]     divisor_reg;

    logic [RegW:0]       trial;
    logic                fits;
    logic [RegW-1:0]     rem_next;
    logic [RegW-1:0]     quo_next;

    // shared compare and subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[RegW-1]};
        fits     = trial >= {1'b0, divisor_reg};
        rem_next = fits ? RegW'(trial - {1'b0, divisor_reg}) : trial[RegW-1:0];
        quo_next = {quo_reg[RegW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == DivCntW'(RegW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && divisor_reg != '0) |-> (rem_reg < divisor_reg))
        else $error("partial remainder not below divisor");

endmodule

// ===== rtl/core/daily_window_slot_trigger.sv =====
// ----------------------------------------------------------------------------
// daily_window_slot_trigger
// pulses slot_due when a new interval slot begins inside a daily time window
// ----------------------------------------------------------------------------
// Each poll (clock_valid, hour, minute) gives exactly one slot_due result. A
// poll with an invalid clock or outside the window passes through the evaluate
// state and then offers its result (0) in the result state. A poll inside the
// window runs the distance from the window start through the bit-serial
// divider, one quotient bit per cycle, and offers its result after the evaluate
// state and the divide phase; the result is held while out_ready stays low.
// in_ready is low from the cycle after the input transfer until the cycle after
// the result transfer, so at most one poll is in flight. Configuration writes
// are taken at any time (cfg_ready is tied high) and must only be issued while
// no poll is in flight.
module daily_window_slot_trigger
(
    input  logic                          clk,
    input  logic                          rst_n,
    // poll channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          clock_valid,
    input  logic [4:0]                    hour_of_day,
    input  logic [5:0]                    minute_of_hour,
    // result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          slot_due,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dwst_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [dwst_pkg::RegW-1:0]     cfg_data
);
    import dwst_pkg::*;

    state_t           state_reg;
    state_t           state_next;

    // configuration registers
    logic [RegW-1:0]  win_start_reg;
    logic [RegW-1:0]  win_end_reg;
    logic [RegW-1:0]  interval_reg;

    // slot tracking state
    logic [RegW-1:0]  held_slot_reg;
    logic             held_valid_reg;
    logic             primed_reg;
    logic             slot_due_reg;

    // captured poll
    logic             clk_ok_reg;
    logic [RegW-1:0]  now_reg;

    logic             in_xfer;
    logic             win_hit;
    logic             div_start;
    logic [RegW-1:0]  div_dividend;
    logic [RegW-1:0]  div_divisor;
    logic [RegW-1:0]  div_quotient;
    div_status_t      div_status;

    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration writes, unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= WindowStartReset;
            win_end_reg   <= WindowEndReset;
            interval_reg  <= IntervalReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WINDOW_START: win_start_reg <= cfg_data;
                CFG_WINDOW_END:   win_end_reg   <= cfg_data;
                CFG_INTERVAL:     interval_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // window test, end inclusive, wraps past midnight when end is below start
    always_comb
    begin
        if (win_start_reg <= win_end_reg)
        begin
            win_hit = (now_reg >= win_start_reg) && (now_reg <= win_end_reg);
        end
        else
        begin
            win_hit = (now_reg >= win_start_reg) || (now_reg <= win_end_reg);
        end
    end

    // distance from window start, zero interval acts as one
    assign div_dividend = day_distance(now_reg, win_start_reg);
    assign div_divisor  = (interval_reg == '0) ? RegW'(1) : interval_reg;

    dwst_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (clk_ok_reg && win_hit)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:   in_ready  = 1'b1;
            ST_EVAL:   div_start = clk_ok_reg && win_hit;
            ST_DIV:    ;
            ST_RESULT: out_valid = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // poll capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            clk_ok_reg <= clock_valid;
            now_reg    <= minute_of_day(hour_of_day, minute_of_hour);
        end
    end

    // slot tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_slot_reg  <= '0;
            held_valid_reg <= 1'b0;
            primed_reg     <= 1'b0;
            slot_due_reg   <= 1'b0;
        end
        else if (state_reg == ST_EVAL)
        begin
            slot_due_reg <= 1'b0;
            if (!clk_ok_reg)
            begin
                // clock lost: forget everything
                primed_reg     <= 1'b0;
                held_valid_reg <= 1'b0;
                held_slot_reg  <= '0;
            end
            else if (!win_hit)
            begin
                held_valid_reg <= 1'b0;
                held_slot_reg  <= '0;
                primed_reg     <= 1'b1;
            end
        end
        else if (state_reg == ST_DIV && div_status.done)
        begin
            if (!primed_reg)
            begin
                // first valid read in the window only adopts its slot
                primed_reg     <= 1'b1;
                held_slot_reg  <= div_quotient;
                held_valid_reg <= 1'b1;
            end
            else if (!held_valid_reg || div_quotient != held_slot_reg)
            begin
                held_slot_reg  <= div_quotient;
                held_valid_reg <= 1'b1;
                slot_due_reg   <= 1'b1;
            end
        end
    end

    assign slot_due = slot_due_reg;

    a_held_needs_primed: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> primed_reg)
        else $error("slot held without primed flag");

    a_due_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && slot_due) |-> held_valid_reg)
        else $error("slot pulse without a held slot");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("new poll taken while a result is pending");

endmodule
